[design/nns_pkg.sv]
package nns_pkg;

  // sizes of the stored source image and of the destination grid
  localparam int unsigned MaxSrcWidth  = 256;
  localparam int unsigned MaxSrcHeight = 256;
  localparam int unsigned MaxDstSide   = 1024;

  // fixed field widths of the ports
  localparam int unsigned ReqW     = 1;
  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 10;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned Pix565W  = 16;
  localparam int unsigned SrcRegW  = 9;
  localparam int unsigned DstRegW  = 11;
  localparam int unsigned FmtW     = 1;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // register reset values
  localparam int unsigned SrcSizeRst = 256;
  localparam int unsigned DstSizeRst = 0;

  // derived datapath widths
  localparam int unsigned MaxSrc   = (MaxSrcWidth > MaxSrcHeight) ? MaxSrcWidth : MaxSrcHeight;
  localparam int unsigned MaxDiv   = (MaxDstSide > MaxSrc) ? MaxDstSide : MaxSrc;
  localparam int unsigned SwW      = $clog2(MaxSrcWidth + 1);
  localparam int unsigned ShW      = $clog2(MaxSrcHeight + 1);
  localparam int unsigned SrcSizeW = $clog2(MaxSrc + 1);
  localparam int unsigned DivW     = $clog2(MaxDiv + 1);
  localparam int unsigned NumW     = ColW + SrcSizeW;
  // quotient is always below the source size
  localparam int unsigned QuoW     = (MaxSrc > 4) ? $clog2(MaxSrc) : 2;
  localparam int unsigned StepCntW = $clog2(QuoW);
  localparam int unsigned ImgDepth = MaxSrcWidth * MaxSrcHeight;
  localparam int unsigned ImgAw    = (ImgDepth > 1) ? $clog2(ImgDepth) : 1;

  localparam logic [ReqW-1:0] ReqLoad  = 1'b0;
  localparam logic [ReqW-1:0] ReqFetch = 1'b1;

  localparam logic [FmtW-1:0] FmtRgb565 = 1'b0;
  localparam logic [FmtW-1:0] FmtRgb888 = 1'b1;

  localparam logic [ChanW-1:0] RedMask   = 8'hF8;
  localparam logic [ChanW-1:0] GreenMask = 8'hFC;
  localparam int unsigned      BlueShift = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcWidth  = 3'd0,
    CfgSrcHeight = 3'd1,
    CfgDstWidth  = 3'd2,
    CfgDstHeight = 3'd3,
    CfgOutFormat = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StLoad,
    StMul,
    StDiv,
    StRead
  } state_e;

  typedef struct packed {
    logic capture;
    logic write;
    logic mul;
    logic step;
    logic read;
  } cmd_t;

  function automatic logic [Pix565W-1:0] pack565(input logic [PixW-1:0] px);
    logic [ChanW-1:0] r;
    logic [ChanW-1:0] g;
    logic [ChanW-1:0] b;
    logic [31:0]      acc;
    r = px[PixW-1 -: ChanW];
    g = px[2*ChanW-1 -: ChanW];
    b = px[ChanW-1:0];
    acc = (32'(r & RedMask) << 8) | (32'(g & GreenMask) << 3) | (32'(b) >> BlueShift);
    return acc[Pix565W-1:0];
  endfunction

endpackage

[design/nns_divider.sv]
// one restoring divider lane, one quotient bit per step
module nns_divider (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [nns_pkg::NumW-1:0]    num_i,
  input  logic [nns_pkg::DivW-1:0]    den_i,
  output logic [nns_pkg::QuoW-1:0]    quo_o
);

  logic [nns_pkg::DivW-1:0] rem_q, rem_d;
  logic [nns_pkg::QuoW-1:0] qn_q, qn_d;
  logic [nns_pkg::DivW:0]   trial;
  logic [nns_pkg::DivW:0]   diff;
  logic                     ge;

  always_comb begin
    trial = {rem_q, qn_q[nns_pkg::QuoW-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = rem_q;
    qn_d  = qn_q;
    if (load_i) begin
      // top bits stay below the divisor since the quotient fits in QuoW bits
      rem_d = nns_pkg::DivW'(num_i >> nns_pkg::QuoW);
      qn_d  = num_i[nns_pkg::QuoW-1:0];
    end else if (step_i) begin
      rem_d = ge ? diff[nns_pkg::DivW-1:0] : trial[nns_pkg::DivW-1:0];
      qn_d  = {qn_q[nns_pkg::QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qn_q  <= qn_d;
  end

  assign quo_o = qn_q;

endmodule

[design/nns_ctrl.sv]
module nns_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_fetch_i,
  output logic          busy_o,
  output nns_pkg::cmd_t cmd_o
);

  localparam logic [nns_pkg::StepCntW-1:0] LastStep = nns_pkg::StepCntW'(nns_pkg::QuoW - 1);

  nns_pkg::state_e                state_q, state_d;
  logic [nns_pkg::StepCntW-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nns_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = (state_q != nns_pkg::StIdle);
    case (state_q)
      nns_pkg::StIdle: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d = req_fetch_i ? nns_pkg::StMul : nns_pkg::StLoad;
        end
      end
      nns_pkg::StLoad: begin
        cmd_o.write = 1'b1;
        state_d = nns_pkg::StIdle;
      end
      nns_pkg::StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d = '0;
        state_d = nns_pkg::StDiv;
      end
      nns_pkg::StDiv: begin
        cmd_o.step = 1'b1;
        if (cnt_q == LastStep) begin
          state_d = nns_pkg::StRead;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      nns_pkg::StRead: begin
        cmd_o.read = 1'b1;
        state_d = nns_pkg::StIdle;
      end
      default: begin
        state_d = nns_pkg::StIdle;
      end
    endcase
  end

endmodule

[design/nns_datapath.sv]
module nns_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nns_pkg::cmd_t                 cmd_i,
  input  logic [nns_pkg::ColW-1:0]      col_i,
  input  logic [nns_pkg::RowW-1:0]      row_i,
  input  logic [nns_pkg::ChanW-1:0]     red_in_i,
  input  logic [nns_pkg::ChanW-1:0]     green_in_i,
  input  logic [nns_pkg::ChanW-1:0]     blue_in_i,
  input  logic                          cfg_we_i,
  input  logic [nns_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nns_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [nns_pkg::Pix565W-1:0]   pixel_565_o,
  output logic [nns_pkg::ChanW-1:0]     red_out_o,
  output logic [nns_pkg::ChanW-1:0]     green_out_o,
  output logic [nns_pkg::ChanW-1:0]     blue_out_o,
  output logic                          range_error_o
);

  logic [nns_pkg::SrcRegW-1:0]  src_width_q, src_height_q;
  logic [nns_pkg::DstRegW-1:0]  dst_width_q, dst_height_q;
  logic [nns_pkg::FmtW-1:0]     out_format_q;

  logic [nns_pkg::ColW-1:0]     col_q;
  logic [nns_pkg::RowW-1:0]     row_q;
  logic [nns_pkg::PixW-1:0]     pix_q;
  logic                         err_q;
  logic [nns_pkg::PixW-1:0]     rd_data_q;
  logic                         res_valid_q;

  logic [nns_pkg::SrcSizeW-1:0] sw_eff, sh_eff;
  logic [nns_pkg::DivW-1:0]     dw_eff, dh_eff;
  logic [nns_pkg::NumW-1:0]     num_x, num_y;
  logic [nns_pkg::QuoW-1:0]     quo_x, quo_y;
  logic                         load_ok;
  logic                         fetch_err;
  logic [nns_pkg::ImgAw-1:0]    wr_addr, rd_addr;

  logic [nns_pkg::PixW-1:0]     img_mem [nns_pkg::ImgDepth];

  // zero source size counts as one, larger sizes saturate
  always_comb begin
    if (src_width_q == '0) begin
      sw_eff = nns_pkg::SrcSizeW'(1);
    end else if (32'(src_width_q) > nns_pkg::MaxSrcWidth) begin
      sw_eff = nns_pkg::SrcSizeW'(nns_pkg::MaxSrcWidth);
    end else begin
      sw_eff = nns_pkg::SrcSizeW'(src_width_q);
    end
    if (src_height_q == '0) begin
      sh_eff = nns_pkg::SrcSizeW'(1);
    end else if (32'(src_height_q) > nns_pkg::MaxSrcHeight) begin
      sh_eff = nns_pkg::SrcSizeW'(nns_pkg::MaxSrcHeight);
    end else begin
      sh_eff = nns_pkg::SrcSizeW'(src_height_q);
    end
    // zero destination size follows the source size
    if (dst_width_q == '0) begin
      dw_eff = nns_pkg::DivW'(sw_eff);
    end else if (32'(dst_width_q) > nns_pkg::MaxDstSide) begin
      dw_eff = nns_pkg::DivW'(nns_pkg::MaxDstSide);
    end else begin
      dw_eff = nns_pkg::DivW'(dst_width_q);
    end
    if (dst_height_q == '0) begin
      dh_eff = nns_pkg::DivW'(sh_eff);
    end else if (32'(dst_height_q) > nns_pkg::MaxDstSide) begin
      dh_eff = nns_pkg::DivW'(nns_pkg::MaxDstSide);
    end else begin
      dh_eff = nns_pkg::DivW'(dst_height_q);
    end
  end

  assign load_ok   = (32'(col_q) < 32'(sw_eff)) && (32'(row_q) < 32'(sh_eff));
  assign fetch_err = (32'(col_q) >= 32'(dw_eff)) || (32'(row_q) >= 32'(dh_eff));
  assign num_x     = nns_pkg::NumW'(col_q) * nns_pkg::NumW'(sw_eff);
  assign num_y     = nns_pkg::NumW'(row_q) * nns_pkg::NumW'(sh_eff);
  assign wr_addr   = nns_pkg::ImgAw'(32'(row_q) * nns_pkg::MaxSrcWidth + 32'(col_q));
  assign rd_addr   = nns_pkg::ImgAw'(32'(quo_y) * nns_pkg::MaxSrcWidth + 32'(quo_x));

  nns_divider u_div_x (
    .clk_i  (clk_i),
    .load_i (cmd_i.mul),
    .step_i (cmd_i.step),
    .num_i  (num_x),
    .den_i  (dw_eff),
    .quo_o  (quo_x)
  );

  nns_divider u_div_y (
    .clk_i  (clk_i),
    .load_i (cmd_i.mul),
    .step_i (cmd_i.step),
    .num_i  (num_y),
    .den_i  (dh_eff),
    .quo_o  (quo_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= nns_pkg::SrcRegW'(nns_pkg::SrcSizeRst);
      src_height_q <= nns_pkg::SrcRegW'(nns_pkg::SrcSizeRst);
      dst_width_q  <= nns_pkg::DstRegW'(nns_pkg::DstSizeRst);
      dst_height_q <= nns_pkg::DstRegW'(nns_pkg::DstSizeRst);
      out_format_q <= nns_pkg::FmtRgb565;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.read;
      if (cfg_we_i) begin
        case (nns_pkg::cfg_idx_e'(cfg_index_i))
          nns_pkg::CfgSrcWidth:  src_width_q  <= cfg_data_i[nns_pkg::SrcRegW-1:0];
          nns_pkg::CfgSrcHeight: src_height_q <= cfg_data_i[nns_pkg::SrcRegW-1:0];
          nns_pkg::CfgDstWidth:  dst_width_q  <= cfg_data_i[nns_pkg::DstRegW-1:0];
          nns_pkg::CfgDstHeight: dst_height_q <= cfg_data_i[nns_pkg::DstRegW-1:0];
          nns_pkg::CfgOutFormat: out_format_q <= cfg_data_i[nns_pkg::FmtW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= col_i;
      row_q <= row_i;
      pix_q <= {red_in_i, green_in_i, blue_in_i};
    end
    if (cmd_i.mul) begin
      err_q <= fetch_err;
    end
  end

  // source image store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && load_ok) begin
      img_mem[wr_addr] <= pix_q;
    end
    if (cmd_i.read) begin
      rd_data_q <= img_mem[rd_addr];
    end
  end

  always_comb begin
    pixel_565_o   = '0;
    red_out_o     = '0;
    green_out_o   = '0;
    blue_out_o    = '0;
    range_error_o = err_q;
    if (!err_q) begin
      if (out_format_q == nns_pkg::FmtRgb565) begin
        pixel_565_o = nns_pkg::pack565(rd_data_q);
      end else begin
        red_out_o   = rd_data_q[nns_pkg::PixW-1 -: nns_pkg::ChanW];
        green_out_o = rd_data_q[2*nns_pkg::ChanW-1 -: nns_pkg::ChanW];
        blue_out_o  = rd_data_q[nns_pkg::ChanW-1:0];
      end
    end
  end

  assign result_valid_o = res_valid_q;

endmodule

[design/nearest_neighbor_scaler_rgb565_unit.sv]
// Nearest-neighbor scaler: load requests (req_type 0) write one RGB888 pixel into the
// 256x256 source store and give no result; fetch requests (req_type 1) map a destination
// column/row to floor(col*sw/dw), floor(row*sh/dh) and return one result, either RGB565 or
// RGB888, or zeros with range_error set when the coordinate lies outside the destination
// size. A transaction is taken when start is high and busy is low. A load keeps the block
// busy in its write state after acceptance, so a new request can follow once it is idle.
// A fetch steps through a multiply state for the two multiplies, then the divide state
// of two parallel restoring dividers that produce one quotient bit per cycle (this sets
// the fetch rate), then a read state for the registered memory read, then returns to idle.
// result_valid_o is high for exactly one cycle, in the same cycle in which busy falls,
// and cannot be stalled; a new request may be accepted in that same cycle.
// Configuration writes are always ready and must only be issued while the block is idle.
module nearest_neighbor_scaler_rgb565_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [nns_pkg::ReqW-1:0]      req_type_i,
  input  logic [nns_pkg::ColW-1:0]      col_i,
  input  logic [nns_pkg::RowW-1:0]      row_i,
  input  logic [nns_pkg::ChanW-1:0]     red_in_i,
  input  logic [nns_pkg::ChanW-1:0]     green_in_i,
  input  logic [nns_pkg::ChanW-1:0]     blue_in_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nns_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nns_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [nns_pkg::Pix565W-1:0]   pixel_565_o,
  output logic [nns_pkg::ChanW-1:0]     red_out_o,
  output logic [nns_pkg::ChanW-1:0]     green_out_o,
  output logic [nns_pkg::ChanW-1:0]     blue_out_o,
  output logic                          range_error_o
);

  nns_pkg::cmd_t cmd;
  logic          req_fetch;

  assign cfg_ready_o = 1'b1;
  assign req_fetch   = (req_type_i == nns_pkg::ReqFetch);

  nns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_fetch_i (req_fetch),
    .busy_o      (busy),
    .cmd_o       (cmd)
  );

  nns_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .col_i          (col_i),
    .row_i          (row_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .pixel_565_o    (pixel_565_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .range_error_o  (range_error_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  a_strobe_ends_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(busy) && !busy))
    else $error("result strobe not at the end of a fetch");

  a_error_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && range_error_o) |->
      (pixel_565_o == '0 && red_out_o == '0 && green_out_o == '0 && blue_out_o == '0))
    else $error("range error result carries nonzero pixel data");

endmodule

[verif/nearest_neighbor_scaler_rgb565_unit_tb.sv]
`timescale 1ns / 1ps

module nearest_neighbor_scaler_rgb565_unit_tb;

  typedef struct packed {
    logic [nns_pkg::ReqW-1:0]  kind;
    logic [nns_pkg::ColW-1:0]  col;
    logic [nns_pkg::RowW-1:0]  row;
    logic [nns_pkg::ChanW-1:0] red;
    logic [nns_pkg::ChanW-1:0] green;
    logic [nns_pkg::ChanW-1:0] blue;
    logic [4:0]                gap;
    logic                      drain;
  } pixel_req_t;

  typedef struct packed {
    logic [nns_pkg::Pix565W-1:0] pix565;
    logic [nns_pkg::ChanW-1:0]   red;
    logic [nns_pkg::ChanW-1:0]   green;
    logic [nns_pkg::ChanW-1:0]   blue;
    logic                        range_error;
  } pixel_res_t;

  typedef struct packed {
    logic [nns_pkg::SrcRegW-1:0] src_w;
    logic [nns_pkg::SrcRegW-1:0] src_h;
    logic [nns_pkg::DstRegW-1:0] dst_w;
    logic [nns_pkg::DstRegW-1:0] dst_h;
    logic [nns_pkg::FmtW-1:0]    fmt;
  } scaler_cfg_t;

  localparam scaler_cfg_t CfgAtReset = '{
    src_w: nns_pkg::SrcRegW'(nns_pkg::SrcSizeRst),
    src_h: nns_pkg::SrcRegW'(nns_pkg::SrcSizeRst),
    dst_w: nns_pkg::DstRegW'(nns_pkg::DstSizeRst),
    dst_h: nns_pkg::DstRegW'(nns_pkg::DstSizeRst),
    fmt:   nns_pkg::FmtRgb565
  };

  localparam int unsigned SettleCycles = 16;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [nns_pkg::ReqW-1:0]      req_type_i = '0;
  logic [nns_pkg::ColW-1:0]      col_i = '0;
  logic [nns_pkg::RowW-1:0]      row_i = '0;
  logic [nns_pkg::ChanW-1:0]     red_in_i = '0;
  logic [nns_pkg::ChanW-1:0]     green_in_i = '0;
  logic [nns_pkg::ChanW-1:0]     blue_in_i = '0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [nns_pkg::CfgIdxW-1:0]   cfg_index_i = '0;
  logic [nns_pkg::CfgDataW-1:0]  cfg_data_i = '0;
  logic                          result_valid_o;
  logic [nns_pkg::Pix565W-1:0]   pixel_565_o;
  logic [nns_pkg::ChanW-1:0]     red_out_o;
  logic [nns_pkg::ChanW-1:0]     green_out_o;
  logic [nns_pkg::ChanW-1:0]     blue_out_o;
  logic                          range_error_o;

  nearest_neighbor_scaler_rgb565_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .pixel_565_o    (pixel_565_o),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .range_error_o  (range_error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scaler state as seen by accepted transactions
  scaler_cfg_t               live_cfg = CfgAtReset;
  logic [nns_pkg::PixW-1:0]  image_model [nns_pkg::ImgDepth];
  pixel_res_t                pending_pixels [$];

  // generator side: settings being planned and which source entries hold data
  scaler_cfg_t      plan_cfg = CfgAtReset;
  bit               loaded_map [nns_pkg::ImgDepth];
  pixel_req_t       request_q [$];
  int               idle_mode = 2;

  pixel_req_t       cur_req = '0;
  bit               have_item = 1'b0;
  int               gap_left = 0;
  logic             launch;
  pixel_res_t       want_px;

  int unsigned      mismatches = 0;
  int unsigned      n_loads = 0;
  int unsigned      n_loads_dropped = 0;
  int unsigned      n_fetches = 0;
  int unsigned      n_fetch_errors = 0;
  int unsigned      n_fetch_888 = 0;
  int unsigned      n_settings = 1;

  function automatic int unsigned src_extent(logic [nns_pkg::SrcRegW-1:0] raw,
                                             int unsigned lim);
    if (raw == 0) return 1;
    return (raw > lim) ? lim : int'(raw);
  endfunction

  function automatic int unsigned dst_extent(logic [nns_pkg::DstRegW-1:0] raw,
                                             int unsigned src);
    if (raw == 0) return src;
    return (raw > nns_pkg::MaxDstSide) ? nns_pkg::MaxDstSide : int'(raw);
  endfunction

  function automatic scaler_cfg_t with_reg(scaler_cfg_t c, logic [nns_pkg::CfgIdxW-1:0] idx,
                                           logic [nns_pkg::CfgDataW-1:0] data);
    scaler_cfg_t n;
    n = c;
    case (idx)
      nns_pkg::CfgSrcWidth:  n.src_w = data[nns_pkg::SrcRegW-1:0];
      nns_pkg::CfgSrcHeight: n.src_h = data[nns_pkg::SrcRegW-1:0];
      nns_pkg::CfgDstWidth:  n.dst_w = data[nns_pkg::DstRegW-1:0];
      nns_pkg::CfgDstHeight: n.dst_h = data[nns_pkg::DstRegW-1:0];
      nns_pkg::CfgOutFormat: n.fmt = data[nns_pkg::FmtW-1:0];
      default: ;
    endcase
    return n;
  endfunction

  // applies one accepted transaction to the image and queues the pixel it returns
  function automatic void resolve_request(pixel_req_t r);
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned sx;
    int unsigned sy;
    logic [nns_pkg::PixW-1:0] px;
    pixel_res_t res;
    sw = src_extent(live_cfg.src_w, nns_pkg::MaxSrcWidth);
    sh = src_extent(live_cfg.src_h, nns_pkg::MaxSrcHeight);
    if (r.kind == nns_pkg::ReqLoad) begin
      n_loads++;
      if (r.col < sw && r.row < sh) begin
        image_model[r.row * nns_pkg::MaxSrcWidth + r.col] = {r.red, r.green, r.blue};
      end else begin
        n_loads_dropped++;
      end
      return;
    end
    dw = dst_extent(live_cfg.dst_w, sw);
    dh = dst_extent(live_cfg.dst_h, sh);
    res = '0;
    n_fetches++;
    if (r.col >= dw || r.row >= dh) begin
      res.range_error = 1'b1;
      n_fetch_errors++;
    end else begin
      sx = r.col * sw / dw;
      sy = r.row * sh / dh;
      px = image_model[sy * nns_pkg::MaxSrcWidth + sx];
      if (live_cfg.fmt == nns_pkg::FmtRgb565) begin
        res.pix565 = {px[23:19], px[15:10], px[7:3]};
      end else begin
        {res.red, res.green, res.blue} = px;
        n_fetch_888++;
      end
    end
    pending_pixels.push_back(res);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int unsigned pick_coord(int unsigned lim);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel == 1) return lim - 1;
    return $urandom_range(0, lim - 1);
  endfunction

  function automatic void push_request(logic [nns_pkg::ReqW-1:0] kind, int unsigned col,
                                       int unsigned row, logic [nns_pkg::ChanW-1:0] red,
                                       logic [nns_pkg::ChanW-1:0] green,
                                       logic [nns_pkg::ChanW-1:0] blue);
    pixel_req_t r;
    r.kind = kind;
    r.col = nns_pkg::ColW'(col);
    r.row = nns_pkg::RowW'(row);
    r.red = red;
    r.green = green;
    r.blue = blue;
    if (idle_mode == 0 || (idle_mode == 2 && $urandom_range(0, 1) == 0)) begin
      r.gap = '0;
    end else begin
      r.gap = 5'($urandom_range(0, 17));
    end
    r.drain = ($urandom_range(0, 49) == 0);
    request_q.push_back(r);
  endfunction

  function automatic void push_load(int unsigned col, int unsigned row,
                                    logic [nns_pkg::ChanW-1:0] red,
                                    logic [nns_pkg::ChanW-1:0] green,
                                    logic [nns_pkg::ChanW-1:0] blue);
    int unsigned sw;
    int unsigned sh;
    sw = src_extent(plan_cfg.src_w, nns_pkg::MaxSrcWidth);
    sh = src_extent(plan_cfg.src_h, nns_pkg::MaxSrcHeight);
    if (col < sw && row < sh) loaded_map[row * nns_pkg::MaxSrcWidth + col] = 1'b1;
    push_request(nns_pkg::ReqLoad, col, row, red, green, blue);
  endfunction

  // a fetch that lands on an empty source entry gets a load there first
  function automatic void push_fetch(int unsigned col, int unsigned row);
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    int unsigned sx;
    int unsigned sy;
    sw = src_extent(plan_cfg.src_w, nns_pkg::MaxSrcWidth);
    sh = src_extent(plan_cfg.src_h, nns_pkg::MaxSrcHeight);
    dw = dst_extent(plan_cfg.dst_w, sw);
    dh = dst_extent(plan_cfg.dst_h, sh);
    if (col < dw && row < dh) begin
      sx = col * sw / dw;
      sy = row * sh / dh;
      if (!loaded_map[sy * nns_pkg::MaxSrcWidth + sx]) begin
        push_load(sx, sy, 8'($urandom()), 8'($urandom()), 8'($urandom()));
      end
    end
    push_request(nns_pkg::ReqFetch, col, row, '0, '0, '0);
  endfunction

  // adds n_items transactions to the queue, hidden loads and dropped loads included
  function automatic void fill_random(int unsigned n_items);
    int unsigned base;
    int unsigned sel;
    int unsigned sw;
    int unsigned sh;
    int unsigned dw;
    int unsigned dh;
    base = request_q.size();
    sw = src_extent(plan_cfg.src_w, nns_pkg::MaxSrcWidth);
    sh = src_extent(plan_cfg.src_h, nns_pkg::MaxSrcHeight);
    dw = dst_extent(plan_cfg.dst_w, sw);
    dh = dst_extent(plan_cfg.dst_h, sh);
    while (request_q.size() < base + n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        push_load(pick_coord(sw), pick_coord(sh),
                  8'($urandom()), 8'($urandom()), 8'($urandom()));
      end else if (sel < 36) begin
        // outside the source, dropped by the block
        if ($urandom_range(0, 1)) begin
          push_load($urandom_range(sw, 1023), $urandom_range(0, 1023),
                    8'($urandom()), 8'($urandom()), 8'($urandom()));
        end else begin
          push_load($urandom_range(0, 1023), $urandom_range(sh, 1023),
                    8'($urandom()), 8'($urandom()), 8'($urandom()));
        end
      end else if (sel < 45 && (dw < nns_pkg::MaxDstSide || dh < nns_pkg::MaxDstSide)) begin
        if (dw < nns_pkg::MaxDstSide && (dh == nns_pkg::MaxDstSide || $urandom_range(0, 1)))
        begin
          push_fetch($urandom_range(dw, 1023), $urandom_range(0, 1023));
        end else begin
          push_fetch($urandom_range(0, 1023), $urandom_range(dh, 1023));
        end
      end else begin
        push_fetch(pick_coord(dw), pick_coord(dh));
      end
    end
  endfunction

  task automatic wait_idle();
    while (request_q.size() > 0 || have_item || pending_pixels.size() > 0) begin
      @(posedge clk_i);
    end
    // a trailing load gives no result but may still be in flight
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [nns_pkg::CfgIdxW-1:0] idx,
                           logic [nns_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    plan_cfg = with_reg(plan_cfg, idx, data);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_scaler(logic [nns_pkg::CfgDataW-1:0] sw,
                                logic [nns_pkg::CfgDataW-1:0] sh,
                                logic [nns_pkg::CfgDataW-1:0] dw,
                                logic [nns_pkg::CfgDataW-1:0] dh,
                                logic [nns_pkg::CfgDataW-1:0] fmt, bit with_unused);
    wait_idle();
    write_reg(nns_pkg::CfgSrcWidth, sw);
    write_reg(nns_pkg::CfgSrcHeight, sh);
    write_reg(nns_pkg::CfgDstWidth, dw);
    write_reg(nns_pkg::CfgDstHeight, dh);
    write_reg(nns_pkg::CfgOutFormat, fmt);
    if (with_unused) begin
      for (int i = int'(nns_pkg::CfgOutFormat) + 1; i < (1 << nns_pkg::CfgIdxW); i++) begin
        write_reg(nns_pkg::CfgIdxW'(i), nns_pkg::CfgDataW'($urandom()));
      end
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // driver: one transaction at a time from request_q, with a drawn gap before each
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      have_item = 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        resolve_request(cur_req);
        have_item = 1'b0;
      end
      if (!have_item && request_q.size() > 0) begin
        cur_req = request_q.pop_front();
        have_item = 1'b1;
        gap_left = int'(cur_req.gap);
      end
      launch = 1'b0;
      if (have_item) begin
        if (start && busy) begin
          launch = 1'b1;
        end else if (cur_req.drain && pending_pixels.size() > 0) begin
          launch = 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          launch = 1'b1;
        end
      end
      start <= launch;
      req_type_i <= cur_req.kind;
      col_i <= cur_req.col;
      row_i <= cur_req.row;
      red_in_i <= cur_req.red;
      green_in_i <= cur_req.green;
      blue_in_i <= cur_req.blue;
    end
  end

  // monitor: register writes and result strobes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        live_cfg = with_reg(live_cfg, cfg_index_i, cfg_data_i);
      end
      if (result_valid_o) begin
        if (pending_pixels.size() == 0) begin
          $error("result with no fetch outstanding");
          mismatches++;
        end else begin
          want_px = pending_pixels.pop_front();
          compare_field("pixel_565", 32'(want_px.pix565), 32'(pixel_565_o));
          compare_field("red_out", 32'(want_px.red), 32'(red_out_o));
          compare_field("green_out", 32'(want_px.green), 32'(green_out_o));
          compare_field("blue_out", 32'(want_px.blue), 32'(blue_out_o));
          compare_field("range_error", 32'(want_px.range_error), 32'(range_error_o));
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the default 256x256 image, dropped loads, errored fetches
    idle_mode = 2;
    push_load(0, 0, 8'hFF, 8'hFF, 8'hFF);
    push_load(255, 255, 8'h00, 8'h00, 8'h00);
    push_load(255, 0, 8'h80, 8'h41, 8'h0F);
    push_load(0, 255, 8'hA5, 8'h5A, 8'hC3);
    push_load(17, 200, 8'h07, 8'h03, 8'hF8);
    push_load(256, 0, 8'h12, 8'h34, 8'h56);
    push_load(0, 1023, 8'h12, 8'h34, 8'h56);
    push_load(1023, 1023, 8'hFF, 8'hFF, 8'hFF);
    push_fetch(0, 0);
    push_fetch(255, 255);
    push_fetch(255, 0);
    push_fetch(0, 255);
    push_fetch(17, 200);
    push_fetch(256, 0);
    push_fetch(0, 256);
    push_fetch(1023, 0);
    push_fetch(1023, 1023);
    push_fetch(0, 0);
    request_q[request_q.size() - 1].drain = 1'b1;
    fill_random(70);

    // single source pixel blown up to the largest destination
    idle_mode = 1;
    program_scaler(nns_pkg::CfgDataW'(1), nns_pkg::CfgDataW'(1),
                   nns_pkg::CfgDataW'(nns_pkg::MaxDstSide),
                   nns_pkg::CfgDataW'(nns_pkg::MaxDstSide),
                   nns_pkg::CfgDataW'(nns_pkg::FmtRgb888), 1'b1);
    fill_random(70);

    // whole source squeezed into one destination pixel
    idle_mode = 0;
    program_scaler(nns_pkg::CfgDataW'(nns_pkg::MaxSrcWidth),
                   nns_pkg::CfgDataW'(nns_pkg::MaxSrcHeight),
                   nns_pkg::CfgDataW'(1), nns_pkg::CfgDataW'(1),
                   nns_pkg::CfgDataW'(nns_pkg::FmtRgb565), 1'b0);
    fill_random(40);

    // register values past their ranges: zero width, saturated height and dst width
    idle_mode = 1;
    program_scaler(11'h200, 11'h7FF, 11'h7FF, 11'h000,
                   nns_pkg::CfgDataW'(nns_pkg::FmtRgb888), 1'b0);
    fill_random(70);

    for (int p = 0; p < 6; p++) begin
      idle_mode = $urandom_range(0, 2);
      program_scaler(
        nns_pkg::CfgDataW'($urandom_range(0, 1) ? $urandom_range(1, 16)
                                                : $urandom_range(1, 256)),
        nns_pkg::CfgDataW'($urandom_range(0, 1) ? $urandom_range(1, 16)
                                                : $urandom_range(1, 256)),
        nns_pkg::CfgDataW'(($urandom_range(0, 4) == 0) ? 0
                                                       : $urandom_range(1, nns_pkg::MaxDstSide)),
        nns_pkg::CfgDataW'(($urandom_range(0, 4) == 0) ? 0
                                                       : $urandom_range(1, nns_pkg::MaxDstSide)),
        nns_pkg::CfgDataW'($urandom_range(0, 1)), 1'b0);
      fill_random(65);
    end

    while (request_q.size() > 0 || have_item || pending_pixels.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    $display("covered %0d loads (%0d outside the source) and %0d fetches (%0d out of range)",
             n_loads, n_loads_dropped, n_fetches, n_fetch_errors);
    $display("across %0d scaler settings, %0d fetches returned as RGB888",
             n_settings, n_fetch_888);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout waiting for the scaler");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
